// File: hw/rtl/lep_pkg.sv
// shared types and constants for the log end probe search block
`timescale 1ns / 1ps

package lep_pkg;

    localparam int STAMP_W     = 64;
    localparam int MAX_CELLS_W = 19;
    localparam int ADDR_W      = 24;
    localparam int PROBE_W     = 18;
    localparam int END_W       = 19;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STAMP = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STORE_READY = 2'd0,
        CFG_MAX_CELLS   = 2'd1,
        CFG_LOG_BASE    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                   store_ready;
        logic [MAX_CELLS_W-1:0] max_cells;
        logic [ADDR_W-1:0]      log_base_address;
    } t_cfg;

    typedef struct packed {
        logic               read_request;
        logic [PROBE_W-1:0] probe_index;
        logic [ADDR_W-1:0]  probe_address;
        logic               search_done;
        logic               log_full;
        logic [END_W-1:0]   end_index;
    } t_result;

endpackage

// File: hw/rtl/lep_in_if.sv
// input channel: start or read-back stamp transactions
`timescale 1ns / 1ps

interface lep_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [lep_pkg::STAMP_W-1:0] cell_stamp;

    modport source (output valid, output kind, output cell_stamp, input ready);
    modport sink (input valid, input kind, input cell_stamp, output ready);
endinterface

// File: hw/rtl/lep_out_if.sv
// output channel: probe request or search result transactions
`timescale 1ns / 1ps

interface lep_out_if;
    logic                        valid;
    logic                        ready;
    logic                        read_request;
    logic [lep_pkg::PROBE_W-1:0] probe_index;
    logic [lep_pkg::ADDR_W-1:0]  probe_address;
    logic                        search_done;
    logic                        log_full;
    logic [lep_pkg::END_W-1:0]   end_index;

    modport source (
        output valid, output read_request, output probe_index, output probe_address,
        output search_done, output log_full, output end_index, input ready
    );
    modport sink (
        input valid, input read_request, input probe_index, input probe_address,
        input search_done, input log_full, input end_index, output ready
    );
endinterface

// File: hw/rtl/lep_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface lep_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lep_pkg::CFG_IDX_W-1:0]  index;
    logic [lep_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/log_end_probe_search_core.sv
// top level of the log end probe search block
`timescale 1ns / 1ps

// Finds the first unused cell of an append-only flash log. A start transaction
// (kind 0) yields a read request for cell 0, or full; each stamp transaction
// (kind 1) during a search carries the stamp read from the last requested cell
// and yields either the next read request or the end of the search (end index,
// or full). A new transaction is accepted every cycle while the output register
// is empty or being emptied: the decision is made combinationally from the
// input and the search registers and lands in the output register in the cycle
// after acceptance. Configuration writes are taken at any cycle and should only
// be made while no search is running.

module log_end_probe_search_core #(
    parameter int INITIAL_STEP = 4096,
    parameter int CELL_BYTES   = 64,
    parameter int INDEX_BITS   = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lep_in_if.sink     i_in,
    lep_cfg_if.sink    i_cfg,
    lep_out_if.source  o_out
);

    localparam int STEP_W = $clog2(INITIAL_STEP + 1);

    lep_pkg::t_cfg           r_cfg;
    logic [INDEX_BITS-1:0]   r_pos;
    logic [STEP_W-1:0]       r_step;
    logic                    r_searching;
    logic                    r_out_valid;
    lep_pkg::t_result        r_result;

    logic [INDEX_BITS-1:0]   n_pos;
    logic [STEP_W-1:0]       n_step;
    logic                    n_searching;
    lep_pkg::t_result        n_result;
    logic                    in_take;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_take     = i_in.valid && i_in.ready;

    lep_next #(
        .INITIAL_STEP (INITIAL_STEP),
        .CELL_BYTES   (CELL_BYTES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_next (
        .i_kind       (i_in.kind),
        .i_cell_stamp (i_in.cell_stamp),
        .i_cfg        (r_cfg),
        .i_pos        (r_pos),
        .i_step       (r_step),
        .i_searching  (r_searching),
        .o_pos        (n_pos),
        .o_step       (n_step),
        .o_searching  (n_searching),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (lep_pkg::t_cfg_index'(i_cfg.index))
                lep_pkg::CFG_STORE_READY: r_cfg.store_ready <= i_cfg.data[0];
                lep_pkg::CFG_MAX_CELLS:
                    r_cfg.max_cells <= i_cfg.data[lep_pkg::MAX_CELLS_W-1:0];
                lep_pkg::CFG_LOG_BASE:
                    r_cfg.log_base_address <= i_cfg.data[lep_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_step      <= STEP_W'(INITIAL_STEP);
            r_searching <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_pos       <= n_pos;
            r_step      <= n_step;
            r_searching <= n_searching;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.read_request  = r_result.read_request;
    assign o_out.probe_index   = r_result.probe_index;
    assign o_out.probe_address = r_result.probe_address;
    assign o_out.search_done   = r_result.search_done;
    assign o_out.log_full      = r_result.log_full;
    assign o_out.end_index     = r_result.end_index;

    a_req_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.read_request && r_result.search_done))
        else $error("result both requests a read and ends the search");

    a_full_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.log_full |-> r_result.search_done)
        else $error("full reported without search end");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_out_valid)
        else $error("accepted transaction produced no result");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && n_result.search_done |=> !r_searching)
        else $error("search still running after its end was reported");

endmodule

// File: hw/rtl/lep_next.sv
// probe decision logic: next search state and result for one transaction
`timescale 1ns / 1ps

module lep_next #(
    parameter int INITIAL_STEP = 4096,
    parameter int CELL_BYTES   = 64,
    parameter int INDEX_BITS   = 18,
    localparam int STEP_W      = $clog2(INITIAL_STEP + 1),
    localparam int WW          = (INDEX_BITS + 1 > 24) ? INDEX_BITS + 1 : 24
) (
    input  logic                         i_kind,
    input  logic [lep_pkg::STAMP_W-1:0]  i_cell_stamp,
    input  lep_pkg::t_cfg                i_cfg,
    input  logic [INDEX_BITS-1:0]        i_pos,
    input  logic [STEP_W-1:0]            i_step,
    input  logic                         i_searching,
    output logic [INDEX_BITS-1:0]        o_pos,
    output logic [STEP_W-1:0]            o_step,
    output logic                         o_searching,
    output lep_pkg::t_result             o_result
);

    localparam logic [WW-1:0]     LIMIT_CAP = WW'(1) << INDEX_BITS;
    localparam logic [WW-1:0]     CELL_W    = WW'(CELL_BYTES);
    localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(INITIAL_STEP);

    logic [WW-1:0]     lim_even;
    logic [WW-1:0]     limit;
    logic [WW-1:0]     pos_w;
    logic [WW-1:0]     step_w;
    logic [WW-1:0]     back;
    logic [WW-1:0]     cand;
    logic [WW-1:0]     offset;
    logic [STEP_W-1:0] half;
    logic              stamp_ok;
    logic              do_probe;

    always_comb begin
        lim_even = WW'({i_cfg.max_cells[lep_pkg::MAX_CELLS_W-1:1], 1'b0});
        limit    = (lim_even > LIMIT_CAP) ? LIMIT_CAP : lim_even;
        pos_w    = WW'(i_pos);
        step_w   = WW'(i_step);
        stamp_ok = (i_cell_stamp != '0) && (i_cell_stamp != '1);
        half     = i_step >> 1;
        back     = (pos_w >= step_w) ? pos_w - step_w : '0;

        o_pos       = i_pos;
        o_step      = i_step;
        o_searching = i_searching;
        o_result    = '0;
        do_probe    = 1'b0;
        cand        = '0;

        if (lep_pkg::t_kind'(i_kind) == lep_pkg::KIND_START) begin
            o_pos  = '0;
            o_step = STEP_INIT;
            if (!i_cfg.store_ready) begin
                o_searching          = 1'b0;
                o_result.search_done = 1'b1;
                o_result.log_full    = 1'b1;
            end else begin
                o_searching = 1'b1;
                do_probe    = 1'b1;
            end
        end else if (i_searching) begin
            if (stamp_ok) begin
                cand     = pos_w + step_w;
                do_probe = 1'b1;
            end else if (i_pos == '0) begin
                o_searching          = 1'b0;
                o_result.search_done = 1'b1;
            end else if (i_step <= STEP_W'(1)) begin
                o_searching          = 1'b0;
                o_result.search_done = 1'b1;
                o_result.end_index   = pos_w[lep_pkg::END_W-1:0];
            end else begin
                o_step   = half;
                cand     = back + WW'(half);
                do_probe = 1'b1;
            end
        end

        offset = cand * CELL_W;
        if (do_probe) begin
            o_pos = cand[INDEX_BITS-1:0];
            if (cand >= limit) begin
                o_searching          = 1'b0;
                o_result.search_done = 1'b1;
                o_result.log_full    = 1'b1;
            end else begin
                o_result.read_request  = 1'b1;
                o_result.probe_index   = cand[lep_pkg::PROBE_W-1:0];
                o_result.probe_address = i_cfg.log_base_address
                                         + offset[lep_pkg::ADDR_W-1:0];
            end
        end
    end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the log end probe search core
`timescale 1ns / 1ps

module testbench;
    import lep_pkg::*;

    localparam int INITIAL_STEP   = 4096;
    localparam int CELL_BYTES     = 64;
    localparam int INDEX_BITS     = 18;
    localparam int ITEM_TARGET    = 1950;
    localparam int PHASE_ITEMS    = 240;
    localparam int IDLE_SWAP_AT   = 650;
    localparam int IDLE_OFF_AT    = 1300;
    localparam int HOLD_AT        = 1400;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SCRIPT_ROWS    = 35;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    localparam t_result RES_IDLE = '0;
    localparam t_result RES_FULL = '{1'b0, 18'd0, 24'd0, 1'b1, 1'b1, 19'd0};
    localparam t_result RES_END0 = '{1'b0, 18'd0, 24'd0, 1'b1, 1'b0, 19'd0};

    typedef struct packed {
        bit          is_cfg;
        t_cfg_index  reg_index;
        logic [23:0] reg_value;
        t_kind       kind;
        logic [63:0] stamp;
        bit          typed;
        t_result     expected;
    } t_script_row;

    localparam t_script_row SEARCH_SCRIPT [SCRIPT_ROWS] = '{
        // reset state: idle response, start with storage not ready
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd0, 1'b1, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, ALL_ONES, 1'b1, RES_FULL},
        // zero and odd cell limits
        '{1'b1, CFG_STORE_READY, 24'd1, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1, RES_FULL},
        '{1'b1, CFG_MAX_CELLS, 24'd1, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1, RES_FULL},
        // two cells at the top of the address space
        '{1'b1, CFG_MAX_CELLS, 24'd2, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b1, CFG_LOG_BASE, 24'hFFFFFF, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'hFFFFFF, 1'b0, 1'b0, 19'd0}},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd0, 1'b1, RES_END0},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd0, 1'b1, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'hFFFFFF, 1'b0, 1'b0, 19'd0}},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, ALL_ONES, 1'b1, RES_END0},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'hFFFFFF, 1'b0, 1'b0, 19'd0}},
        // overshoot past the limit reports full
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd1, 1'b1, RES_FULL},
        // oversized limit, clamped
        '{1'b1, CFG_MAX_CELLS, 24'h07FFFF, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b1, CFG_LOG_BASE, 24'd0, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'd0, 1'b0, 1'b0, 19'd0}},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'h8000_0000_0000_0000, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, RES_IDLE},
        // storage readiness dropped during a search is ignored
        '{1'b1, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, ALL_ONES, 1'b0, RES_IDLE},
        '{1'b1, CFG_STORE_READY, 24'd1, KIND_START, 64'd0, 1'b0, RES_IDLE},
        // restart while searching
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'd0, 1'b0, 1'b0, 19'd0}},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'h0000_0001_0000_0000, 1'b0, RES_IDLE},
        // start with storage not ready aborts, later stamps are idle
        '{1'b1, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1, RES_FULL},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd1, 1'b1, RES_IDLE},
        // exact maximum limit, address wrap
        '{1'b1, CFG_STORE_READY, 24'd1, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b1, CFG_MAX_CELLS, 24'h040000, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b1, CFG_LOG_BASE, 24'hFFFFC0, KIND_START, 64'd0, 1'b0, RES_IDLE},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_START, 64'd0, 1'b1,
          '{1'b1, 18'd0, 24'hFFFFC0, 1'b0, 1'b0, 19'd0}},
        '{1'b0, CFG_STORE_READY, 24'd0, KIND_STAMP, 64'd5, 1'b0, RES_IDLE}
    };

    logic i_clk;
    logic i_rst_n;

    lep_in_if  in_if ();
    lep_cfg_if cfg_if ();
    lep_out_if out_if ();

    log_end_probe_search_core #(
        .INITIAL_STEP(INITIAL_STEP),
        .CELL_BYTES  (CELL_BYTES),
        .INDEX_BITS  (INDEX_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    // register shadows and search state of the predictor
    logic        cfg_ready;
    logic [18:0] cfg_max_cells;
    logic [23:0] cfg_base;
    logic [18:0] search_pos;
    logic [12:0] search_step;
    bit          search_active;

    t_result pending_results[$];
    int      items_sent;
    int      mismatch_count;
    int      hold_left;
    bit      hold_done;
    int      stall_cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [18:0] cell_limit();
        logic [18:0] lim;
        lim = {cfg_max_cells[18:1], 1'b0};
        if (lim > 19'(1 << INDEX_BITS)) begin
            lim = 19'(1 << INDEX_BITS);
        end
        return lim;
    endfunction

    function automatic t_result next_probe_result(input t_kind kind, input logic [63:0] stamp);
        t_result r;
        r = '0;
        if (kind == KIND_START) begin
            search_pos  = '0;
            search_step = 13'(INITIAL_STEP);
            if (!cfg_ready) begin
                search_active = 1'b0;
                r.search_done = 1'b1;
                r.log_full    = 1'b1;
                return r;
            end
            search_active = 1'b1;
        end else begin
            if (!search_active) begin
                return r;
            end
            if (stamp != 64'd0 && stamp != ALL_ONES) begin
                search_pos = search_pos + search_step;
            end else begin
                if (search_pos == 0 || search_step <= 1) begin
                    search_active = 1'b0;
                    r.search_done = 1'b1;
                    r.end_index   = search_pos;
                    return r;
                end
                search_pos  = (search_pos >= search_step) ? search_pos - search_step : '0;
                search_step = search_step >> 1;
                search_pos  = search_pos + search_step;
            end
        end
        if (search_pos >= cell_limit()) begin
            search_active = 1'b0;
            r.search_done = 1'b1;
            r.log_full    = 1'b1;
        end else begin
            r.read_request  = 1'b1;
            r.probe_index   = search_pos[17:0];
            r.probe_address = cfg_base + 24'(search_pos * CELL_BYTES);
        end
        return r;
    endfunction

    task automatic send_item(input t_kind kind, input logic [63:0] stamp,
                             input bit typed, input t_result typed_result);
        int      idle_pct;
        t_result predicted;
        idle_pct = (items_sent < IDLE_SWAP_AT) ? 21 : (items_sent < IDLE_OFF_AT) ? 66 : 0;
        while ($urandom_range(99, 0) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.cell_stamp <= stamp;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = next_probe_result(kind, stamp);
        pending_results.push_back(typed ? typed_result : predicted);
        items_sent++;
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [23:0] value);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_STORE_READY: cfg_ready     = value[0];
            CFG_MAX_CELLS:   cfg_max_cells = value[18:0];
            CFG_LOG_BASE:    cfg_base      = value;
            default: ;
        endcase
    endtask

    // result checking and receiver flow control
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        int      idle_pct;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen = '{out_if.read_request, out_if.probe_index, out_if.probe_address,
                     out_if.search_done, out_if.log_full, out_if.end_index};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result transaction: req=%0d idx=%0d addr=%h done=%0d full=%0d end=%0d",
                             seen.read_request, seen.probe_index, seen.probe_address,
                             seen.search_done, seen.log_full, seen.end_index);
                end
            end else begin
                want = pending_results.pop_front();
                if (seen.read_request !== want.read_request ||
                    seen.probe_index !== want.probe_index ||
                    seen.probe_address !== want.probe_address ||
                    seen.search_done !== want.search_done ||
                    seen.log_full !== want.log_full ||
                    seen.end_index !== want.end_index) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp: req=%0d idx=%0d addr=%h done=%0d full=%0d end=%0d",
                                 want.read_request, want.probe_index, want.probe_address,
                                 want.search_done, want.log_full, want.end_index);
                        $display("         got: req=%0d idx=%0d addr=%h done=%0d full=%0d end=%0d",
                                 seen.read_request, seen.probe_index, seen.probe_address,
                                 seen.search_done, seen.log_full, seen.end_index);
                    end
                end
            end
        end
        idle_pct = (items_sent < IDLE_SWAP_AT) ? 66 : (items_sent < IDLE_OFF_AT) ? 21 : 0;
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          phase_end;
        int          pick;
        logic        new_ready;
        logic [18:0] new_cells;
        logic [23:0] new_base;
        logic [18:0] log_end;
        logic [63:0] stamp;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_START;
        in_if.cell_stamp = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_STORE_READY;
        cfg_if.data      = '0;
        out_if.ready     = 1'b0;
        cfg_ready        = 1'b0;
        cfg_max_cells    = '0;
        cfg_base         = '0;
        search_pos       = '0;
        search_step      = 13'(INITIAL_STEP);
        search_active    = 1'b0;
        items_sent       = 0;
        mismatch_count   = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        stall_cycles     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < SCRIPT_ROWS; row++) begin
            if (SEARCH_SCRIPT[row].is_cfg) begin
                write_register(SEARCH_SCRIPT[row].reg_index, SEARCH_SCRIPT[row].reg_value);
            end else begin
                send_item(SEARCH_SCRIPT[row].kind, SEARCH_SCRIPT[row].stamp,
                          SEARCH_SCRIPT[row].typed, SEARCH_SCRIPT[row].expected);
            end
        end

        for (int phase = 0; phase < 8 && items_sent < ITEM_TARGET; phase++) begin
            new_ready = 1'b1;
            new_base  = 24'($urandom);
            case (phase)
                0: new_cells = 19'h40000;
                1: begin
                    new_cells = 19'h7FFFF;
                    new_base  = 24'hFFFFFF;
                end
                2: new_cells = 19'($urandom_range(64, 0));
                3: new_cells = 19'($urandom_range(20000, 4097));
                4: begin
                    new_ready = 1'b0;
                    new_cells = 19'($urandom);
                end
                5: new_cells = 19'($urandom);
                6: begin
                    new_cells = 19'h3FFFF;
                    new_base  = 24'd0;
                end
                default: new_cells = 19'($urandom_range(262144, 8192));
            endcase
            write_register(CFG_STORE_READY, {23'd0, new_ready});
            write_register(CFG_MAX_CELLS, {5'd0, new_cells});
            write_register(CFG_LOG_BASE, new_base);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(99, 0) < 10) begin
                    // stray transaction, random kind and stamp
                    send_item(t_kind'($urandom_range(1, 0)), {$urandom, $urandom}, 1'b0, RES_IDLE);
                end else begin
                    pick = $urandom_range(99, 0);
                    if (pick < 15) log_end = '0;
                    else if (pick < 30) log_end = cell_limit();
                    else if (pick < 55) log_end = 19'($urandom_range(16, 1));
                    else log_end = 19'($urandom_range(cell_limit(), 0));
                    send_item(KIND_START, {$urandom, $urandom}, 1'b0, RES_IDLE);
                    while (search_active && items_sent < phase_end) begin
                        pick = $urandom_range(99, 0);
                        if (pick < 3) break;
                        if (pick < 6) begin
                            stamp = {$urandom, $urandom};
                        end else if (search_pos < log_end) begin
                            case ($urandom_range(2, 0))
                                0: stamp = 64'd1 << $urandom_range(63, 0);
                                1: stamp = ~(64'd1 << $urandom_range(63, 0));
                                default: stamp = {$urandom, $urandom} | 64'd1;
                            endcase
                        end else begin
                            stamp = $urandom_range(1, 0) ? ALL_ONES : 64'd0;
                        end
                        send_item(KIND_STAMP, stamp, 1'b0, RES_IDLE);
                    end
                end
            end
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
